/* sv/assert_macros.svh */
// Assertion helpers shared by the sequencer modules.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define SNFCS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that a condition is followed by a property in the next cycle.
`define SNFCS_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

/* sv/snfcs_pkg.sv */
// ----------------------------------------------------------------------------
// snfcs_pkg
// Shared types, opcodes and transfer scripts of the SPI NOR command sequencer.
// ----------------------------------------------------------------------------
package snfcs_pkg;

	// Flash address width and mask of the address bits sent to the flash
	localparam int          FLASH_ADDR_BITS = 24;
	localparam logic [31:0] FLASH_ADDR_MASK = 32'((64'd1 << FLASH_ADDR_BITS) - 64'd1);

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// Request codes
	localparam logic [2:0] REQ_CHIP_ERASE   = 3'd0;
	localparam logic [2:0] REQ_SECTOR_ERASE = 3'd1;
	localparam logic [2:0] REQ_PROG_BEGIN   = 3'd2;
	localparam logic [2:0] REQ_PROG_BYTE    = 3'd3;
	localparam logic [2:0] REQ_VERIFY_BEGIN = 3'd4;
	localparam logic [2:0] REQ_VERIFY_BYTE  = 3'd5;
	localparam logic [2:0] REQ_REPLY        = 3'd6;

	// Flash opcodes
	localparam logic [7:0] OP_WREN  = 8'h06;
	localparam logic [7:0] OP_RDSR  = 8'h05;
	localparam logic [7:0] OP_PP    = 8'h02;
	localparam logic [7:0] OP_SE    = 8'h20;
	localparam logic [7:0] OP_CE    = 8'hC7;
	localparam logic [7:0] OP_READ  = 8'h03;
	localparam logic [7:0] DUMMY    = 8'hFF;
	localparam int         BUSY_BIT = 0;

	// Output actions
	typedef enum logic [1:0] {
		ACT_KEEP     = 2'd0,
		ACT_SEND_REL = 2'd1,
		ACT_REL      = 2'd2,
		ACT_REPORT   = 2'd3
	} act_t;

	// Transfer scripts the back end plays out
	typedef enum logic [3:0] {
		K_POLL       = 4'd0,
		K_PBYTE      = 4'd1,
		K_PLAST      = 4'd2,
		K_DUMMY      = 4'd3,
		K_DONE       = 4'd4,
		K_PRE_VERIFY = 4'd5,
		K_PRE_CE     = 4'd6,
		K_PRE_SE     = 4'd7,
		K_PRE_PP     = 4'd8
	} kind_t;

	// Command passed from front to back
	typedef struct packed {
		kind_t       kind;
		logic [31:0] addr;
		logic [7:0]  data;
		logic        mismatch;
	} cmd_t;

	// One result item
	typedef struct packed {
		act_t        action;
		logic [7:0]  mosi_byte;
		logic        wants_reply;
		logic [31:0] report_address;
		logic        mismatch;
		logic        last_of_run;
	} res_item_t;

	// Build a transfer item with no report fields
	function automatic res_item_t mk(act_t act, logic [7:0] b, logic want, logic last);
		res_item_t r;
		r = '0;
		r.action      = act;
		r.mosi_byte   = b;
		r.wants_reply = want;
		r.last_of_run = last;
		return r;
	endfunction

	// Item number step of the script of command c
	function automatic res_item_t script_item(cmd_t c, logic [2:0] step);
		res_item_t   r;
		logic [23:0] a;
		r = '0;
		a = c.addr[23:0];
		unique case (c.kind)
			K_POLL: begin
				r = (step == 3'd0) ? mk(ACT_KEEP, OP_RDSR, 1'b0, 1'b0)
				                   : mk(ACT_KEEP, DUMMY, 1'b1, 1'b1);
			end
			K_PBYTE: r = mk(ACT_KEEP, c.data, 1'b0, 1'b1);
			K_PLAST: begin
				unique case (step)
					3'd0:    r = mk(ACT_SEND_REL, c.data, 1'b0, 1'b0);
					3'd1:    r = mk(ACT_KEEP, OP_RDSR, 1'b0, 1'b0);
					default: r = mk(ACT_KEEP, DUMMY, 1'b1, 1'b1);
				endcase
			end
			K_DUMMY: r = mk(ACT_KEEP, DUMMY, 1'b1, 1'b1);
			K_DONE: begin
				if (step == 3'd0) begin
					r = mk(ACT_REL, 8'h00, 1'b0, 1'b0);
				end else begin
					r = mk(ACT_REPORT, 8'h00, 1'b0, 1'b1);
					r.report_address = c.addr;
					r.mismatch       = c.mismatch;
				end
			end
			K_PRE_VERIFY: begin
				unique case (step)
					3'd0:    r = mk(ACT_REL, 8'h00, 1'b0, 1'b0);
					3'd1:    r = mk(ACT_KEEP, OP_READ, 1'b0, 1'b0);
					3'd2:    r = mk(ACT_KEEP, a[23:16], 1'b0, 1'b0);
					3'd3:    r = mk(ACT_KEEP, a[15:8], 1'b0, 1'b0);
					default: r = mk(ACT_KEEP, a[7:0], 1'b0, 1'b1);
				endcase
			end
			K_PRE_CE: begin
				unique case (step)
					3'd0:    r = mk(ACT_REL, 8'h00, 1'b0, 1'b0);
					3'd1:    r = mk(ACT_SEND_REL, OP_WREN, 1'b0, 1'b0);
					3'd2:    r = mk(ACT_SEND_REL, OP_CE, 1'b0, 1'b0);
					3'd3:    r = mk(ACT_KEEP, OP_RDSR, 1'b0, 1'b0);
					default: r = mk(ACT_KEEP, DUMMY, 1'b1, 1'b1);
				endcase
			end
			K_PRE_SE: begin
				unique case (step)
					3'd0:    r = mk(ACT_REL, 8'h00, 1'b0, 1'b0);
					3'd1:    r = mk(ACT_SEND_REL, OP_WREN, 1'b0, 1'b0);
					3'd2:    r = mk(ACT_KEEP, OP_SE, 1'b0, 1'b0);
					3'd3:    r = mk(ACT_KEEP, a[23:16], 1'b0, 1'b0);
					3'd4:    r = mk(ACT_KEEP, a[15:8], 1'b0, 1'b0);
					3'd5:    r = mk(ACT_SEND_REL, a[7:0], 1'b0, 1'b0);
					3'd6:    r = mk(ACT_KEEP, OP_RDSR, 1'b0, 1'b0);
					default: r = mk(ACT_KEEP, DUMMY, 1'b1, 1'b1);
				endcase
			end
			K_PRE_PP: begin
				unique case (step)
					3'd0:    r = mk(ACT_REL, 8'h00, 1'b0, 1'b0);
					3'd1:    r = mk(ACT_SEND_REL, OP_WREN, 1'b0, 1'b0);
					3'd2:    r = mk(ACT_KEEP, OP_PP, 1'b0, 1'b0);
					3'd3:    r = mk(ACT_KEEP, a[23:16], 1'b0, 1'b0);
					3'd4:    r = mk(ACT_KEEP, a[15:8], 1'b0, 1'b0);
					default: r = mk(ACT_KEEP, a[7:0], 1'b0, 1'b1);
				endcase
			end
			default: r = mk(ACT_REL, 8'h00, 1'b0, 1'b1);
		endcase
		return r;
	endfunction

endpackage

/* sv/snfcs_req_if.sv */
// ----------------------------------------------------------------------------
// snfcs_req_if
// Request channel: flash requests and reply bytes into the sequencer.
// ----------------------------------------------------------------------------
interface snfcs_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  req_type;
	logic [31:0] address;
	logic [7:0]  data_byte;
	logic        is_last;

	modport source (output valid, req_type, address, data_byte, is_last, input ready);
	modport sink (input valid, req_type, address, data_byte, is_last, output ready);
endinterface

/* sv/snfcs_res_if.sv */
// ----------------------------------------------------------------------------
// snfcs_res_if
// Result channel: SPI transfer items and operation reports.
// ----------------------------------------------------------------------------
interface snfcs_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  mosi_byte;
	logic        wants_reply;
	logic [31:0] report_address;
	logic        mismatch;
	logic        last_of_run;

	modport source (output valid, action, mosi_byte, wants_reply, report_address,
		mismatch, last_of_run, input ready);
	modport sink (input valid, action, mosi_byte, wants_reply, report_address,
		mismatch, last_of_run, output ready);
endinterface

/* sv/snfcs_front.sv */
// ----------------------------------------------------------------------------
// snfcs_front
// Accepts requests, tracks the operation phase and queues at most one
// transfer script command for each request that fits the current phase.
// ----------------------------------------------------------------------------
module snfcs_front
	import snfcs_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	snfcs_req_if.sink       req,
	input  logic            full,
	output logic            push,
	output cmd_t            cmd
);

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_PRE    = 6'b000010,
		PH_PDATA  = 6'b000100,
		PH_VDATA  = 6'b001000,
		PH_VREPLY = 6'b010000,
		PH_POST   = 6'b100000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [2:0]  pending_q;
	logic [31:0] start_q;
	logic [24:0] index_q;
	logic [24:0] index_inc;
	logic [7:0]  expected_q;
	logic        expected_last_q;
	logic        accept;
	logic        is_begin;

	assign req.ready = !full;
	assign accept    = req.valid && !full;
	assign index_inc = index_q + 25'd1;
	assign is_begin  = (req.req_type == REQ_CHIP_ERASE) || (req.req_type == REQ_SECTOR_ERASE)
		|| (req.req_type == REQ_PROG_BEGIN) || (req.req_type == REQ_VERIFY_BEGIN);

	// Classify the request against the phase
	always_comb begin
		phase_d      = phase_q;
		push         = 1'b0;
		cmd          = '0;
		cmd.kind     = K_DUMMY;
		cmd.data     = req.data_byte;
		if (accept) begin
			if (is_begin) begin
				if (phase_q == PH_IDLE) begin
					push     = 1'b1;
					cmd.kind = K_POLL;
					phase_d  = PH_PRE;
				end
			end else if (req.req_type == REQ_PROG_BYTE) begin
				if (phase_q == PH_PDATA) begin
					push     = 1'b1;
					cmd.kind = req.is_last ? K_PLAST : K_PBYTE;
					phase_d  = req.is_last ? PH_POST : PH_PDATA;
				end
			end else if (req.req_type == REQ_VERIFY_BYTE) begin
				if (phase_q == PH_VDATA) begin
					push     = 1'b1;
					cmd.kind = K_DUMMY;
					phase_d  = PH_VREPLY;
				end
			end else if (req.req_type == REQ_REPLY) begin
				if (phase_q == PH_PRE || phase_q == PH_POST) begin
					push = 1'b1;
					if (req.data_byte[BUSY_BIT]) begin
						cmd.kind = K_DUMMY;
					end else if (phase_q == PH_POST) begin
						cmd.kind = K_DONE;
						phase_d  = PH_IDLE;
					end else begin
						cmd.addr = start_q & FLASH_ADDR_MASK;
						priority if (pending_q == REQ_VERIFY_BEGIN) begin
							cmd.kind = K_PRE_VERIFY;
							phase_d  = PH_VDATA;
						end else if (pending_q == REQ_CHIP_ERASE) begin
							cmd.kind = K_PRE_CE;
							phase_d  = PH_POST;
						end else if (pending_q == REQ_SECTOR_ERASE) begin
							cmd.kind = K_PRE_SE;
							phase_d  = PH_POST;
						end else begin
							cmd.kind = K_PRE_PP;
							phase_d  = PH_PDATA;
						end
					end
				end else if (phase_q == PH_VREPLY) begin
					if (req.data_byte != expected_q) begin
						push         = 1'b1;
						cmd.kind     = K_DONE;
						cmd.addr     = start_q + {7'd0, index_q};
						cmd.mismatch = 1'b1;
						phase_d      = PH_IDLE;
					end else if (expected_last_q) begin
						push     = 1'b1;
						cmd.kind = K_DONE;
						cmd.addr = start_q + {7'd0, index_inc};
						phase_d  = PH_IDLE;
					end else begin
						phase_d  = PH_VDATA;
					end
				end
			end
		end
	end

	// Hold the phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Capture operation context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q       <= REQ_CHIP_ERASE;
			start_q         <= '0;
			index_q         <= '0;
			expected_q      <= '0;
			expected_last_q <= 1'b0;
		end else if (accept) begin
			if (is_begin && phase_q == PH_IDLE) begin
				pending_q <= req.req_type;
				start_q   <= req.address;
				index_q   <= '0;
			end
			if (req.req_type == REQ_VERIFY_BYTE && phase_q == PH_VDATA) begin
				expected_q      <= req.data_byte;
				expected_last_q <= req.is_last;
			end
			if (req.req_type == REQ_REPLY && phase_q == PH_VREPLY
				&& req.data_byte == expected_q) begin
				index_q <= index_inc;
			end
		end
	end

endmodule

/* sv/snfcs_fifo.sv */
// ----------------------------------------------------------------------------
// snfcs_fifo
// Short first-word-fall-through queue of commands between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module snfcs_fifo
	import snfcs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output cmd_t head
);

	cmd_t                   mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign full       = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (QUEUE_PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`SNFCS_ASSERT(a_no_push_full, !(push && full), "push into full queue")
	`SNFCS_ASSERT(a_no_pop_empty, !(pop && !head_valid), "pop from empty queue")
	`SNFCS_ASSERT(a_ptrs_empty, (count_q != '0) || (wr_ptr_q == rd_ptr_q), "pointers differ when empty")

endmodule

/* sv/snfcs_back.sv */
// ----------------------------------------------------------------------------
// snfcs_back
// Plays out the transfer script of the head command, one result item per
// cycle while res.ready does not stall it, into a registered output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module snfcs_back
	import snfcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  cmd_t        head,
	output logic        pop,
	snfcs_res_if.source res
);

	logic [2:0] step_q;
	logic       valid_q;
	res_item_t  item;
	res_item_t  item_q;
	logic       load;

	assign item = script_item(head, step_q);
	assign load = head_valid && (!valid_q || res.ready);
	assign pop  = load && item.last_of_run;

	// Advance through the script
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (!valid_q || res.ready) begin
				valid_q <= head_valid;
			end
			if (load) begin
				step_q <= item.last_of_run ? 3'd0 : step_q + 3'd1;
			end
		end
	end

	// Hold the output item
	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item;
		end
	end

	assign res.valid          = valid_q;
	assign res.action         = item_q.action;
	assign res.mosi_byte      = item_q.mosi_byte;
	assign res.wants_reply    = item_q.wants_reply;
	assign res.report_address = item_q.report_address;
	assign res.mismatch       = item_q.mismatch;
	assign res.last_of_run    = item_q.last_of_run;

	`SNFCS_ASSERT(a_head_in_run, (step_q == 3'd0) || head_valid, "command left mid script")
	`SNFCS_ASSERT_NEXT(a_pop_last, pop, res.valid && res.last_of_run, "pop without last item")
	`SNFCS_ASSERT_NEXT(a_step_inc, load && !item.last_of_run, step_q == $past(step_q) + 3'd1, "step skipped")

endmodule

/* sv/spi_nor_flash_command_sequencer.sv */
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer
// Turns flash requests into SPI byte transfers with chip-select framing.
// ----------------------------------------------------------------------------
// Usage:
//   req carries erase, program, verify requests and the bytes read back from
//   the flash (reply items); res carries transfer items (send keep select,
//   send then release, release only) and one report item per operation.
//   Each transfer item flagged wants_reply returns its received byte as a
//   reply request. Requests that do not fit the current phase are taken and
//   dropped without results.
//   Path: with an empty queue the first result of an item becomes valid once
//   the item has entered the command queue and then loaded the registered
//   output stage.
//   Throughput: one result item per cycle while res.ready stays high; an item
//   yields 0 to 8 results, the back end playing one script step each cycle it
//   is not stalled. A four-entry command queue lets requests keep arriving meanwhile.
//   Reset: phase idle, queue empty, no result valid.
//   Stall: while res.ready is low the result holds; once the queue holds four
//   commands req.ready drops until the back end frees an entry.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer
	import snfcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	snfcs_req_if.sink   req,
	snfcs_res_if.source res
);

	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	logic head_valid;
	cmd_t head;

	snfcs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.full   (full),
		.push   (push),
		.cmd    (push_cmd)
	);

	snfcs_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	snfcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res        (res)
	);

endmodule

/* tb/sv/spi_nor_flash_command_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer_tb
// Self-checking bench for the SPI NOR command sequencer. It plays the host
// and the flash at once, and answers every status poll and read with reply
// items. A behavioral predictor tracks the operation phase and queues the
// transfer and report items that each accepted request should produce. Those
// items are compared field by field with the result channel, under random
// idling on both sides, a long output stall and pauses that drain the block.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer_tb;
	import snfcs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Request code with no meaning to the block
	localparam logic [2:0] REQ_UNUSED = 3'd7;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int MAX_PRINTED    = 40;

	// Operation phase as seen by the host
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PRE,
		PH_PDATA,
		PH_VDATA,
		PH_VREPLY,
		PH_POST
	} seq_phase_t;

	logic clk;
	logic arst_n;

	snfcs_req_if req_if ();
	snfcs_res_if res_if ();

	spi_nor_flash_command_sequencer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.res    (res_if)
	);

	// Predicted sequencer state
	seq_phase_t  seq_phase        = PH_IDLE;
	logic [2:0]  pend_op          = '0;
	logic [31:0] op_start         = '0;
	logic [24:0] verify_count     = '0;
	logic [7:0]  verify_want      = '0;
	logic        verify_want_last = 1'b0;

	// Transfer items expected on the result channel, oldest first
	res_item_t   expected_q[$];
	res_item_t   run_buf[8];
	int          run_len;

	// Idling control and bookkeeping
	bit          tx_idle_off    = 1'b0;
	bit          rx_idle_off    = 1'b0;
	int          rx_hold_cycles = 0;
	int          error_count    = 0;
	int          effective_items = 0;
	int          results_seen   = 0;
	int          quiet_cycles   = 0;
	int          verify_fails   = 0;
	int unsigned op_count[8];

	// Clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Print one failure line and count it
	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTED) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
		end
	endtask

	// Append one item to the results of the current request
	function automatic void put(act_t act, logic [7:0] b, logic want_reply,
			logic [31:0] rep_addr, logic mis);
		res_item_t r;
		r = '0;
		r.action         = act;
		r.mosi_byte      = b;
		r.wants_reply    = want_reply;
		r.report_address = rep_addr;
		r.mismatch       = mis;
		run_buf[run_len] = r;
		run_len++;
	endfunction

	function automatic void put_status_poll();
		put(ACT_KEEP, OP_RDSR, 1'b0, '0, 1'b0);
		put(ACT_KEEP, DUMMY, 1'b1, '0, 1'b0);
	endfunction

	// Send the flash address high byte first
	function automatic void put_flash_address(act_t last_act);
		logic [31:0] a;
		a = op_start & FLASH_ADDR_MASK;
		put(ACT_KEEP, a[23:16], 1'b0, '0, 1'b0);
		put(ACT_KEEP, a[15:8], 1'b0, '0, 1'b0);
		put(last_act, a[7:0], 1'b0, '0, 1'b0);
	endfunction

	// Advance the predicted state by one request and queue its results
	task automatic predict_request(input logic [2:0] kind, input logic [31:0] addr,
			input logic [7:0] data, input logic last, output bit took_effect);
		seq_phase_t prior;
		res_item_t  r;
		prior   = seq_phase;
		run_len = 0;
		case (kind)
			REQ_CHIP_ERASE, REQ_SECTOR_ERASE, REQ_PROG_BEGIN, REQ_VERIFY_BEGIN: begin
				if (seq_phase == PH_IDLE) begin
					pend_op      = kind;
					op_start     = addr;
					verify_count = '0;
					seq_phase    = PH_PRE;
					op_count[kind]++;
					put_status_poll();
				end
			end
			REQ_PROG_BYTE: begin
				if (seq_phase == PH_PDATA) begin
					if (last) begin
						put(ACT_SEND_REL, data, 1'b0, '0, 1'b0);
						put_status_poll();
						seq_phase = PH_POST;
					end else begin
						put(ACT_KEEP, data, 1'b0, '0, 1'b0);
					end
				end
			end
			REQ_VERIFY_BYTE: begin
				if (seq_phase == PH_VDATA) begin
					verify_want      = data;
					verify_want_last = last;
					put(ACT_KEEP, DUMMY, 1'b1, '0, 1'b0);
					seq_phase = PH_VREPLY;
				end
			end
			REQ_REPLY: begin
				if (seq_phase == PH_PRE || seq_phase == PH_POST) begin
					if (data[BUSY_BIT]) begin
						put(ACT_KEEP, DUMMY, 1'b1, '0, 1'b0);
					end else if (seq_phase == PH_POST) begin
						put(ACT_REL, 8'h00, 1'b0, '0, 1'b0);
						put(ACT_REPORT, 8'h00, 1'b0, '0, 1'b0);
						seq_phase = PH_IDLE;
					end else begin
						put(ACT_REL, 8'h00, 1'b0, '0, 1'b0);
						if (pend_op == REQ_VERIFY_BEGIN) begin
							put(ACT_KEEP, OP_READ, 1'b0, '0, 1'b0);
							put_flash_address(ACT_KEEP);
							seq_phase = PH_VDATA;
						end else begin
							put(ACT_SEND_REL, OP_WREN, 1'b0, '0, 1'b0);
							if (pend_op == REQ_CHIP_ERASE) begin
								put(ACT_SEND_REL, OP_CE, 1'b0, '0, 1'b0);
								put_status_poll();
								seq_phase = PH_POST;
							end else if (pend_op == REQ_SECTOR_ERASE) begin
								put(ACT_KEEP, OP_SE, 1'b0, '0, 1'b0);
								put_flash_address(ACT_SEND_REL);
								put_status_poll();
								seq_phase = PH_POST;
							end else begin
								put(ACT_KEEP, OP_PP, 1'b0, '0, 1'b0);
								put_flash_address(ACT_KEEP);
								seq_phase = PH_PDATA;
							end
						end
					end
				end else if (seq_phase == PH_VREPLY) begin
					if (data != verify_want) begin
						put(ACT_REL, 8'h00, 1'b0, '0, 1'b0);
						put(ACT_REPORT, 8'h00, 1'b0, op_start + {7'd0, verify_count}, 1'b1);
						seq_phase = PH_IDLE;
						verify_fails++;
					end else begin
						verify_count = verify_count + 25'd1;
						if (verify_want_last) begin
							put(ACT_REL, 8'h00, 1'b0, '0, 1'b0);
							put(ACT_REPORT, 8'h00, 1'b0, op_start + {7'd0, verify_count}, 1'b0);
							seq_phase = PH_IDLE;
						end else begin
							seq_phase = PH_VDATA;
						end
					end
				end
			end
			default: ;
		endcase
		for (int i = 0; i < run_len; i++) begin
			r = run_buf[i];
			r.last_of_run = (i == run_len - 1);
			expected_q.push_back(r);
		end
		took_effect = (run_len > 0) || (seq_phase != prior);
	endtask

	// Offer one request after a random gap and hold it until accepted
	task automatic send_request(input logic [2:0] kind, input logic [31:0] addr,
			input logic [7:0] data, input logic last);
		int gap;
		bit took_effect;
		gap = tx_idle_off ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid     <= 1'b1;
		req_if.req_type  <= kind;
		req_if.address   <= addr;
		req_if.data_byte <= data;
		req_if.is_last   <= last;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		predict_request(kind, addr, data, last, took_effect);
		if (took_effect) begin
			effective_items++;
		end
	endtask

	// Drop valid and wait until every expected item has come back
	task automatic wait_for_drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	// Pick the next request that fits the predicted phase, or noise
	task automatic send_flow_item(input int noise_pct);
		logic [2:0] kind;
		logic [31:0] addr;
		logic [7:0] data;
		logic [7:0] flip;
		logic       last;
		addr = $urandom;
		data = 8'($urandom);
		last = 1'($urandom_range(0, 1));
		kind = REQ_UNUSED;
		if ($urandom_range(0, 99) < noise_pct) begin
			kind = 3'($urandom_range(0, 7));
		end else begin
			case (seq_phase)
				PH_IDLE: begin
					case ($urandom_range(0, 3))
						0:       kind = REQ_CHIP_ERASE;
						1:       kind = REQ_SECTOR_ERASE;
						2:       kind = REQ_PROG_BEGIN;
						default: kind = REQ_VERIFY_BEGIN;
					endcase
				end
				PH_PRE, PH_POST: begin
					kind = REQ_REPLY;
					data[BUSY_BIT] = ($urandom_range(0, 3) == 0);
				end
				PH_PDATA: begin
					kind = REQ_PROG_BYTE;
					last = ($urandom_range(0, 3) == 0);
				end
				PH_VDATA: begin
					kind = REQ_VERIFY_BYTE;
					last = ($urandom_range(0, 2) == 0);
				end
				default: begin
					kind = REQ_REPLY;
					data = verify_want;
					if ($urandom_range(0, 5) == 0) begin
						flip = 8'($urandom_range(1, 255));
						data = verify_want ^ flip;
					end
				end
			endcase
		end
		send_request(kind, addr, data, last);
	endtask

	// Chip erase with status polls before and after the erase, busy only before it
	task automatic test_chip_erase();
		send_request(REQ_CHIP_ERASE, 32'h0000_0000, 8'h00, 1'b0);
		send_request(REQ_REPLY, 32'h0000_0000, 8'h01, 1'b0);
		send_request(REQ_REPLY, 32'h0000_0000, 8'h00, 1'b0);
		send_request(REQ_REPLY, 32'h0000_0000, 8'hFE, 1'b0);
	endtask

	// Sector erase at the top address, longest script of eight items
	task automatic test_sector_erase();
		send_request(REQ_SECTOR_ERASE, 32'hFFFF_FFFF, 8'hFF, 1'b1);
		send_request(REQ_REPLY, 32'hFFFF_FFFF, 8'h00, 1'b0);
		send_request(REQ_REPLY, 32'h0000_0000, 8'hFE, 1'b1);
	endtask

	// Two byte page program with the extreme data values
	task automatic test_page_program();
		send_request(REQ_PROG_BEGIN, 32'h00A5_5A3C, 8'h00, 1'b0);
		send_request(REQ_REPLY, 32'h0000_0000, 8'h00, 1'b0);
		send_request(REQ_PROG_BYTE, 32'hFFFF_FFFF, 8'h00, 1'b0);
		send_request(REQ_PROG_BYTE, 32'h0000_0000, 8'hFF, 1'b1);
		send_request(REQ_REPLY, 32'h0000_0000, 8'h00, 1'b0);
	endtask

	// Matching verify whose end address wraps past the 32-bit top
	task automatic test_verify_match();
		send_request(REQ_VERIFY_BEGIN, 32'hFFFF_FFFE, 8'h00, 1'b0);
		send_request(REQ_REPLY, 32'h0000_0000, 8'h00, 1'b0);
		send_request(REQ_VERIFY_BYTE, 32'h0000_0000, 8'hAA, 1'b0);
		send_request(REQ_REPLY, 32'h0000_0000, 8'hAA, 1'b0);
		send_request(REQ_VERIFY_BYTE, 32'h0000_0000, 8'h55, 1'b1);
		send_request(REQ_REPLY, 32'h0000_0000, 8'h55, 1'b0);
	endtask

	// Verify mismatch, with requests that do not fit the phase in between
	task automatic test_verify_mismatch();
		send_request(REQ_VERIFY_BEGIN, 32'h1234_5678, 8'h00, 1'b0);
		send_request(REQ_CHIP_ERASE, 32'h0000_0000, 8'h00, 1'b0);
		send_request(REQ_REPLY, 32'h0000_0000, 8'h00, 1'b0);
		send_request(REQ_PROG_BYTE, 32'h0000_0000, 8'h11, 1'b1);
		send_request(REQ_VERIFY_BYTE, 32'h0000_0000, 8'h3C, 1'b1);
		send_request(REQ_REPLY, 32'h0000_0000, 8'hC3, 1'b0);
	endtask

	// Requests that are dropped while idle
	task automatic test_ignored_requests();
		send_request(REQ_REPLY, 32'hFFFF_FFFF, 8'h00, 1'b1);
		send_request(REQ_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1'b1);
	endtask

	// Mostly well-formed operations with random content and some noise
	task automatic test_random_flow(input int count);
		int target;
		int calls;
		target = effective_items + count;
		calls  = 0;
		while (effective_items < target) begin
			if (calls % 20 == 0) begin
				tx_idle_off = ($urandom_range(0, 3) == 0);
				rx_idle_off = ($urandom_range(0, 3) == 0);
			end
			send_flow_item(10);
			calls++;
		end
		tx_idle_off = 1'b0;
		rx_idle_off = 1'b0;
	endtask

	// Hold the output off for a long stretch while requests keep coming
	task automatic test_output_stall(input int count);
		int target;
		target         = effective_items + count;
		tx_idle_off    = 1'b1;
		rx_hold_cycles = 250;
		while (effective_items < target) send_flow_item(0);
		tx_idle_off = 1'b0;
	endtask

	// Short bursts, each followed by a full drain
	task automatic test_drain_pauses(input int bursts, input int per_burst);
		int target;
		for (int b = 0; b < bursts; b++) begin
			target = effective_items + per_burst;
			while (effective_items < target) send_flow_item(5);
			wait_for_drain();
		end
	endtask

	// Accept results with random stalls and an occasional long hold
	initial begin
		int stall;
		res_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				res_if.ready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end
			stall = rx_idle_off ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (!res_if.valid) @(posedge clk);
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		res_item_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				report_error($sformatf("result item with nothing expected, action %0d",
					res_if.action));
			end else begin
				want = expected_q.pop_front();
				check_field("action", 32'(res_if.action), 32'(want.action));
				check_field("mosi_byte", 32'(res_if.mosi_byte), 32'(want.mosi_byte));
				check_field("wants_reply", 32'(res_if.wants_reply), 32'(want.wants_reply));
				check_field("report_address", res_if.report_address, want.report_address);
				check_field("mismatch", 32'(res_if.mismatch), 32'(want.mismatch));
				check_field("last_of_run", 32'(res_if.last_of_run), 32'(want.last_of_run));
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Reset, stimulus and final verdict
	initial begin
		req_if.valid     = 1'b0;
		req_if.req_type  = REQ_CHIP_ERASE;
		req_if.address   = '0;
		req_if.data_byte = '0;
		req_if.is_last   = 1'b0;
		arst_n           = 1'b0;
		foreach (op_count[i]) op_count[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_chip_erase();
		test_sector_erase();
		test_page_program();
		test_verify_match();
		test_verify_mismatch();
		test_ignored_requests();
		test_random_flow(150);
		test_output_stall(40);
		test_drain_pauses(3, 10);

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_q.size() != 0) begin
			report_error($sformatf("%0d expected items never arrived", expected_q.size()));
		end

		$display("Covered %0d requests: %0d chip erase, %0d sector erase, %0d program, %0d verify",
			effective_items, op_count[REQ_CHIP_ERASE], op_count[REQ_SECTOR_ERASE],
			op_count[REQ_PROG_BEGIN], op_count[REQ_VERIFY_BEGIN]);
		$display("Checked %0d result items; %0d verify runs ended on a mismatch",
			results_seen, verify_fails);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
